// File: rtl/dmpg_pkg.sv
// Shared types and constants of the dithered mask pixel generator.
package dmpg_pkg;

    // Field widths
    localparam int unsigned COORD_W = 12;
    localparam int unsigned SHAPE_W = 3;
    localparam int unsigned SIZE_W  = 13;
    localparam int unsigned VAR_W   = 16;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 16;

    // Hash multipliers
    localparam logic [31:0] HASH_MUL_X   = 32'd73856093;
    localparam logic [31:0] HASH_MUL_Y   = 32'd19349663;
    localparam logic [31:0] HASH_MUL_VAR = 32'd83492791;
    localparam logic [31:0] HASH_MUL_PAN = 32'd2654435761;
    localparam logic [31:0] HASH_MUL_FIN = 32'h85ebca6b;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PANEL_SIZE = 4'd0,
        CFG_VARIANT    = 4'd1
    } t_cfg_idx;

    // Panel shapes
    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_ANTIDIAG  = 3'd0,
        SHAPE_DIAG      = 3'd1,
        SHAPE_LEFT      = 3'd2,
        SHAPE_TOP       = 3'd3,
        SHAPE_CORNER_BR = 3'd4,
        SHAPE_CORNER_BL = 3'd5,
        SHAPE_CORNER_TR = 3'd6,
        SHAPE_CORNER_TL = 3'd7
    } t_shape;

    // Load enables of the hash pipeline registers
    typedef struct packed {
        logic s1;
        logic s2;
    } t_stage_en;

endpackage

// File: rtl/dmpg_ifs.sv
// Handshake interfaces: pixel requests, coverage results, configuration writes.
interface dmpg_pix_if import dmpg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic [SHAPE_W-1:0] panel_index;

    modport source (output valid, pixel_col, pixel_row, panel_index, input ready);
    modport sink   (input valid, pixel_col, pixel_row, panel_index, output ready);
endinterface

interface dmpg_res_if ();
    logic valid;
    logic ready;
    logic covered;

    modport source (output valid, covered, input ready);
    modport sink   (input valid, covered, output ready);
endinterface

interface dmpg_cfg_if import dmpg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/dmpg_hash.sv
// Two-stage pipelined dither hash giving the 16-bit threshold.
module dmpg_hash
    import dmpg_pkg::*;
(
    input  logic               i_clk,
    input  t_stage_en          i_en,
    input  logic [COORD_W-1:0] i_col,
    input  logic [COORD_W-1:0] i_row,
    input  logic [SHAPE_W-1:0] i_shape,
    input  logic [VAR_W-1:0]   i_variant,
    output logic [15:0]        o_thresh
);

    logic [31:0] p_x, p_y, p_var, p_pan;
    logic [31:0] folded;
    logic [31:0] r_mix;
    logic [31:0] r_fin;

    // Stage 1: the four seed products, low 32 bits, merged by xor
    assign p_x   = {20'd0, i_col} * HASH_MUL_X;
    assign p_y   = {20'd0, i_row} * HASH_MUL_Y;
    assign p_var = {16'd0, i_variant} * HASH_MUL_VAR;
    assign p_pan = {29'd0, i_shape} * HASH_MUL_PAN;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_mix <= p_x ^ p_y ^ p_var ^ p_pan;
        end
    end

    // Stage 2: fold and final multiply
    assign folded = r_mix ^ (r_mix >> 13);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_fin <= folded * HASH_MUL_FIN;
        end
    end

    // Last fold: the high half is xored into the low half, 16 bits are kept
    assign o_thresh = r_fin[15:0] ^ r_fin[31:16];

endmodule

// File: rtl/dithered_mask_pixel_gen_core.sv
// Top level of the dithered mask pixel generator: four-stage coverage pipeline.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------
//  i_pix   | in  | valid/ready         | pixel_col[11:0], pixel_row[11:0], panel_index[2:0]
//  o_res   | out | valid/ready         | covered
//  i_cfg   | in  | valid/ready (rdy=1) | index[3:0] (0 panel_size, 1 variant), data[15:0]
//
// One request per clock while the output is not stalled; a result is offered once its request
// has reached the stage 4 register, and leaves when o_res.ready is high.
// Stages: shape distance + hash seeds, scale + hash mix, threshold product, compare.
// Each stage advances when it is empty or the next one moves, so bubbles close up
// under a stalled output and nothing is dropped or repeated.
// Synchronous active-low reset clears valid bits and loads panel_size 256, variant 1.
module dithered_mask_pixel_gen_core
    import dmpg_pkg::*;
#(
    parameter int unsigned MAX_PANEL_SIZE = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmpg_pix_if.sink    i_pix,
    dmpg_res_if.source  o_res,
    dmpg_cfg_if.sink    i_cfg
);

    localparam int unsigned D_W   = SIZE_W + 1;   // shape distance
    localparam int unsigned D25_W = D_W + 5;      // distance times 25
    localparam int unsigned S44_W = SIZE_W + 6;   // 44 * panel size
    localparam int unsigned RHS_W = S44_W + 1 + 16;
    localparam int unsigned CMP_W = D25_W + 18;

    // Configuration registers
    logic [SIZE_W-1:0] r_panel_size;
    logic [VAR_W-1:0]  r_variant;
    logic [S44_W-1:0]  r_s44;
    logic [SIZE_W-1:0] cfg_size;

    assign i_cfg.ready = 1'b1;
    assign cfg_size = (32'(i_cfg.data[SIZE_W-1:0]) > 32'(MAX_PANEL_SIZE))
                    ? SIZE_W'(MAX_PANEL_SIZE) : i_cfg.data[SIZE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_size <= SIZE_W'(256);
            r_variant    <= VAR_W'(1);
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_PANEL_SIZE: r_panel_size <= cfg_size;
                CFG_VARIANT:    r_variant    <= i_cfg.data[VAR_W-1:0];
                default: ;
            endcase
        end
    end

    // 44 * S, refreshed every cycle from the size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s44 <= S44_W'(44 * 256);
        end else begin
            r_s44 <= (S44_W'(r_panel_size) << 5) + (S44_W'(r_panel_size) << 3)
                   + (S44_W'(r_panel_size) << 2);
        end
    end

    // Stage flow control
    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;

    assign adv4 = !r_v4 || o_res.ready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign i_pix.ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_pix.valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    // Hash pipeline runs alongside stages 1 and 2
    t_stage_en   hash_en;
    logic [15:0] thresh;

    assign hash_en.s1 = adv1;
    assign hash_en.s2 = adv2;

    dmpg_hash u_hash (
        .i_clk     (i_clk),
        .i_en      (hash_en),
        .i_col     (i_pix.pixel_col),
        .i_row     (i_pix.pixel_row),
        .i_shape   (i_pix.panel_index),
        .i_variant (r_variant),
        .o_thresh  (thresh)
    );

    // Stage 1: centered coordinates and shape distance
    logic signed [D_W-1:0] ca, cb, na, nb, shape_d;
    logic signed [D_W-1:0] r_d1;

    function automatic logic signed [D_W-1:0] smin(input logic signed [D_W-1:0] p,
                                                  input logic signed [D_W-1:0] q);
        return (p < q) ? p : q;
    endfunction

    function automatic logic signed [D_W-1:0] smax(input logic signed [D_W-1:0] p,
                                                  input logic signed [D_W-1:0] q);
        return (p > q) ? p : q;
    endfunction

    assign ca = $signed({1'b0, r_panel_size}) - $signed({1'b0, i_pix.pixel_col, 1'b0})
              - D_W'(1);
    assign cb = $signed({1'b0, r_panel_size}) - $signed({1'b0, i_pix.pixel_row, 1'b0})
              - D_W'(1);
    assign na = -ca;
    assign nb = -cb;

    always_comb begin
        case (t_shape'(i_pix.panel_index))
            SHAPE_ANTIDIAG:  shape_d = smax(smin(na, cb), smin(ca, nb));
            SHAPE_DIAG:      shape_d = smax(smin(ca, cb), smin(na, nb));
            SHAPE_LEFT:      shape_d = ca;
            SHAPE_TOP:       shape_d = cb;
            SHAPE_CORNER_BR: shape_d = smin(na, nb);
            SHAPE_CORNER_BL: shape_d = smin(ca, nb);
            SHAPE_CORNER_TR: shape_d = smin(na, cb);
            default:         shape_d = smin(ca, cb);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv1) r_d1 <= shape_d;
    end

    // Stage 2: distance times 25 (6553600 = 25 * 2^18)
    logic signed [D25_W-1:0] d1x, r_d2;

    assign d1x = D25_W'(r_d1);

    always_ff @(posedge i_clk) begin
        if (adv2) r_d2 <= (d1x <<< 4) + (d1x <<< 3) + d1x;
    end

    // Stage 3: 44 * S * (h - 32768)
    logic signed [15:0]      hs;
    logic signed [S44_W:0]   s44s;
    logic signed [RHS_W-1:0] r_rhs;
    logic signed [D25_W-1:0] r_d3;

    assign hs   = $signed({~thresh[15], thresh[14:0]});
    assign s44s = $signed({1'b0, r_s44});

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_rhs <= s44s * hs;
            r_d3  <= r_d2;
        end
    end

    // Stage 4: coverage compare into the output register
    logic signed [CMP_W-1:0] lhs, rhs;
    logic                    r_cov;

    assign lhs = $signed({r_d3, 18'd0});
    assign rhs = CMP_W'(r_rhs);

    always_ff @(posedge i_clk) begin
        if (adv4) r_cov <= (lhs > rhs);
    end

    assign o_res.valid   = r_v4;
    assign o_res.covered = r_cov;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the dithered mask pixel generator core.
`timescale 1ns / 1ps

module testbench;
    import dmpg_pkg::*;

    localparam int unsigned PANEL_SIZE_MAX  = 4096;
    localparam int          ITEMS_PER_PHASE = 160;
    localparam int          N_PHASES        = 9;
    localparam int          CALM_PHASE      = 7;    // no idling on either side
    localparam int          BACKLOG_PHASE   = 8;    // long output stall, then a drain pause
    localparam int          SPARE_PHASE     = 5;    // also writes an unmapped register index
    localparam int          HOLDOFF_CYCLES  = 200;
    localparam int          SETTLE_CYCLES   = 12;
    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          MAX_REPORTS     = 10;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd9;

    // Dither hash constants
    localparam logic [31:0] MIX_COL     = 32'd73856093;
    localparam logic [31:0] MIX_ROW     = 32'd19349663;
    localparam logic [31:0] MIX_VARIANT = 32'd83492791;
    localparam logic [31:0] MIX_SHAPE   = 32'd2654435761;
    localparam logic [31:0] MIX_FINAL   = 32'h85ebca6b;

    // Panel size and variant per phase; phase 8 takes a random size, phases 6 to 8 a random variant
    localparam logic [15:0] PHASE_SIZE [N_PHASES] = '{
        16'd16, 16'd4096, 16'hFFFF, 16'd0, 16'd7, 16'h2064, 16'd1000, 16'd256, 16'd333
    };
    localparam logic [15:0] PHASE_VARIANT [N_PHASES] = '{
        16'd0, 16'hFFFF, 16'h5A5A, 16'd12345, 16'd1, 16'd777, 16'hA5C3, 16'd2, 16'd9
    };

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        t_shape             shape;
        logic               known;      // expected value given below
        logic               covered;
    } t_pixel_vec;

    typedef struct {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        t_shape             shape;
        logic               covered;
    } t_coverage_exp;

    // Directed pixels at the reset setting: panel 256, variant 1
    localparam int N_DIRECTED = 25;
    localparam t_pixel_vec DIRECTED [N_DIRECTED] = '{
        '{12'd0,    12'd0,    SHAPE_LEFT,      1'b1, 1'b1},
        '{12'd255,  12'd0,    SHAPE_LEFT,      1'b1, 1'b0},
        '{12'd0,    12'd0,    SHAPE_TOP,       1'b1, 1'b1},
        '{12'd0,    12'd255,  SHAPE_TOP,       1'b1, 1'b0},
        '{12'd0,    12'd0,    SHAPE_CORNER_TL, 1'b1, 1'b1},
        '{12'd0,    12'd0,    SHAPE_CORNER_BR, 1'b1, 1'b0},
        '{12'd255,  12'd255,  SHAPE_CORNER_BR, 1'b1, 1'b1},
        '{12'd0,    12'd255,  SHAPE_CORNER_BL, 1'b1, 1'b1},
        '{12'd255,  12'd0,    SHAPE_CORNER_TR, 1'b1, 1'b1},
        '{12'd255,  12'd0,    SHAPE_ANTIDIAG,  1'b1, 1'b1},
        '{12'd0,    12'd0,    SHAPE_DIAG,      1'b1, 1'b1},
        '{12'd255,  12'd0,    SHAPE_DIAG,      1'b1, 1'b0},
        // far outside the panel
        '{12'd4095, 12'd4095, SHAPE_CORNER_TL, 1'b1, 1'b0},
        '{12'd4095, 12'd4095, SHAPE_CORNER_BR, 1'b1, 1'b1},
        '{12'd0,    12'd4095, SHAPE_ANTIDIAG,  1'b1, 1'b1},
        '{12'd4095, 12'd0,    SHAPE_TOP,       1'b1, 1'b1},
        // around the center, decided by the dither threshold; the last one lies far outside, also predicted
        '{12'd127,  12'd127,  SHAPE_ANTIDIAG,  1'b0, 1'b0},
        '{12'd128,  12'd127,  SHAPE_DIAG,      1'b0, 1'b0},
        '{12'd127,  12'd0,    SHAPE_LEFT,      1'b0, 1'b0},
        '{12'd0,    12'd128,  SHAPE_TOP,       1'b0, 1'b0},
        '{12'd128,  12'd128,  SHAPE_CORNER_BR, 1'b0, 1'b0},
        '{12'd127,  12'd128,  SHAPE_CORNER_BL, 1'b0, 1'b0},
        '{12'd128,  12'd127,  SHAPE_CORNER_TR, 1'b0, 1'b0},
        '{12'd127,  12'd127,  SHAPE_CORNER_TL, 1'b0, 1'b0},
        '{12'd2047, 12'd2048, SHAPE_LEFT,      1'b0, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    dmpg_pix_if pix_if ();
    dmpg_res_if res_if ();
    dmpg_cfg_if cfg_if ();

    // Shadow copy of the registers
    int unsigned        panel_sz = 256;
    logic [VAR_W-1:0]   variant  = 16'd1;

    t_coverage_exp      coverage_q [$];
    t_coverage_exp      oldest;
    int                 fail_count = 0;
    int                 cycle_count = 0;
    bit                 calm = 1'b0;
    bit                 holdoff_req = 1'b0;
    int                 holdoff_left = 0;

    dithered_mask_pixel_gen_core #(
        .MAX_PANEL_SIZE (PANEL_SIZE_MAX)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint lesser(longint p, longint q);
        return (p < q) ? p : q;
    endfunction

    function automatic longint greater(longint p, longint q);
        return (p > q) ? p : q;
    endfunction

    // Coverage of one pixel under the current panel size and variant
    function automatic logic predict_coverage(logic [COORD_W-1:0] col,
                                              logic [COORD_W-1:0] row,
                                              t_shape shape);
        longint      a;
        longint      b;
        longint      shape_d;
        longint      thr;
        logic [31:0] mix;
        a = longint'(panel_sz) - 2 * longint'(col) - 1;
        b = longint'(panel_sz) - 2 * longint'(row) - 1;
        case (shape)
            SHAPE_ANTIDIAG:  shape_d = greater(lesser(-a, b), lesser(a, -b));
            SHAPE_DIAG:      shape_d = greater(lesser(a, b), lesser(-a, -b));
            SHAPE_LEFT:      shape_d = a;
            SHAPE_TOP:       shape_d = b;
            SHAPE_CORNER_BR: shape_d = lesser(-a, -b);
            SHAPE_CORNER_BL: shape_d = lesser(a, -b);
            SHAPE_CORNER_TR: shape_d = lesser(-a, b);
            default:         shape_d = lesser(a, b);
        endcase
        // 32-bit multiplicative hash folded to a 16-bit threshold
        mix = ({20'd0, col} * MIX_COL) ^ ({20'd0, row} * MIX_ROW) ^
              ({16'd0, variant} * MIX_VARIANT) ^ ({29'd0, shape} * MIX_SHAPE);
        mix = mix ^ (mix >> 13);
        mix = mix * MIX_FINAL;
        mix = mix ^ (mix >> 16);
        thr = longint'(mix[15:0]);
        return (shape_d * 64'sd6553600) > (44 * longint'(panel_sz) * (thr - 32768));
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Offer one pixel request; entered and left at a falling edge, valid kept high
    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                              input t_shape shape, input logic known, input logic known_cov);
        t_coverage_exp ent;
        if (!calm && $urandom_range(0, 99) < 12) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_col   <= col;
        pix_if.pixel_row   <= row;
        pix_if.panel_index <= shape;
        do begin
            @(posedge i_clk);
        end while (!pix_if.ready);
        ent.col     = col;
        ent.row     = row;
        ent.shape   = shape;
        ent.covered = known ? known_cov : predict_coverage(col, row, shape);
        coverage_q.push_back(ent);
        @(negedge i_clk);
    endtask

    // Register write; entered and left at a falling edge, valid kept high
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        case (idx)
            CFG_PANEL_SIZE: begin
                panel_sz = int'(val[SIZE_W-1:0]);
                if (panel_sz > PANEL_SIZE_MAX)
                    panel_sz = PANEL_SIZE_MAX;
            end
            CFG_VARIANT: variant = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every expected result is back
    task automatic wait_for_results();
        pix_if.valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (coverage_q.size() != 0);
    endtask

    // Result side: random back-pressure plus an occasional long hold-off
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req) begin
                holdoff_req  = 1'b0;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= !(!calm && $urandom_range(0, 99) < 12);
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (coverage_q.size() == 0) begin
                note_failure($sformatf("unexpected result covered=%0b", res_if.covered));
            end else begin
                oldest = coverage_q.pop_front();
                if (res_if.covered !== oldest.covered)
                    note_failure($sformatf(
                        "x=%0d y=%0d shape=%s S=%0d var=%0d: expected %0b, got %0b",
                        oldest.col, oldest.row, oldest.shape.name(), panel_sz, variant,
                        oldest.covered, res_if.covered));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Main sequence
    initial begin
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        t_shape             shape;
        logic [15:0]        size_val;
        logic [15:0]        var_val;

        pix_if.valid       = 1'b0;
        pix_if.pixel_col   = '0;
        pix_if.pixel_row   = '0;
        pix_if.panel_index = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        i_rst_n            = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed pixels at the reset setting
        for (int i = 0; i < N_DIRECTED; i++)
            send_pixel(DIRECTED[i].col, DIRECTED[i].row, DIRECTED[i].shape,
                       DIRECTED[i].known, DIRECTED[i].covered);

        // Random pixels under a series of register settings
        for (int p = 0; p < N_PHASES; p++) begin
            wait_for_results();
            calm     = (p == CALM_PHASE);
            size_val = (p == N_PHASES - 1) ? 16'($urandom_range(16, 4096)) : PHASE_SIZE[p];
            var_val  = (p >= 6) ? 16'($urandom) : PHASE_VARIANT[p];
            write_reg(CFG_PANEL_SIZE, size_val);
            write_reg(CFG_VARIANT, var_val);
            if (p == SPARE_PHASE)
                write_reg(CFG_IDX_SPARE, 16'($urandom));
            cfg_if.valid <= 1'b0;
            if (p == BACKLOG_PHASE)
                holdoff_req = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                shape = t_shape'($urandom_range(0, 7));
                if (panel_sz == 0 || $urandom_range(0, 9) == 0) begin
                    col = 12'($urandom_range(0, 4095));
                    row = 12'($urandom_range(0, 4095));
                end else begin
                    col = 12'($urandom_range(0, panel_sz - 1));
                    row = 12'($urandom_range(0, panel_sz - 1));
                    // pull toward the panel border and the center lines
                    case ($urandom_range(0, 7))
                        0: col = 12'(panel_sz - 1);
                        1: row = 12'(panel_sz - 1);
                        2: col = 12'(panel_sz / 2);
                        3: row = 12'(panel_sz / 2 - 1);
                        default: ;
                    endcase
                end
                if (p == BACKLOG_PHASE && n == ITEMS_PER_PHASE / 2)
                    wait_for_results();
                send_pixel(col, row, shape, 1'b0, 1'b0);
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
